### rtl/cbop_pkg.sv
// Shared constants, codes and control structs of the bucket owner partitioner.
package cbop_pkg;

	// Sizing
	localparam int MAX_CHILDREN   = 256;
	localparam int MAX_PARTITIONS = 16;
	localparam int OFFSET_BITS    = 48;

	// Field and register widths
	localparam int OP_W     = 2;
	localparam int NODE_W   = 4;
	localparam int PART_W   = 5;
	localparam int CHILD_W  = 9;
	localparam int LOAD_W   = 9;
	localparam int OFF_W    = OFFSET_BITS;
	localparam int CFG_W    = 48;
	localparam int CFG_IX_W = 2;
	localparam int IDX_W    = $clog2(MAX_CHILDREN);
	localparam int PIDX_W   = $clog2(MAX_PARTITIONS);

	// Opcodes
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
	localparam logic [OP_W-1:0] OP_HINT     = 2'd1;
	localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

	// Register indexes
	localparam logic [CFG_IX_W-1:0] REG_ENABLE     = 2'd0;
	localparam logic [CFG_IX_W-1:0] REG_PART_COUNT = 2'd1;
	localparam logic [CFG_IX_W-1:0] REG_CHILD_CNT  = 2'd2;
	localparam logic [CFG_IX_W-1:0] REG_BUCKET_SZ  = 2'd3;

	// Load table read selects
	localparam logic [1:0] LSEL_CAND = 2'd0;
	localparam logic [1:0] LSEL_ZERO = 2'd1;
	localparam logic [1:0] LSEL_SCAN = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_in;
		logic       clear;
		logic       cap_start;
		logic       cap_set;
		logic       hint_apply;
		logic       walk_init;
		logic       walk_next;
		logic       scan_init;
		logic       scan_step;
		logic       place;
		logic       set_ready;
		logic       cls_start;
		logic       cls_look;
		logic       out_load;
		logic [1:0] lsel;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            hint_skip;
		logic            cnt_zero;
		logic            hint_last;
		logic            enabled;
		logic            div_done;
		logic            div_busy;
		logic            walk_end;
		logic            mark_hit;
		logic            scan_end;
		logic            out_free;
	} status_t;

endpackage

### rtl/cbop_div.sv
// Restoring divider, one quotient bit per cycle.
module cbop_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cbop_pkg::OFF_W-1:0] dividend,
	input  logic [cbop_pkg::OFF_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [cbop_pkg::OFF_W-1:0] quotient
);

	localparam int CNT_W = $clog2(cbop_pkg::OFF_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(cbop_pkg::OFF_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [cbop_pkg::OFF_W-1:0] rem_q;
	logic [cbop_pkg::OFF_W-1:0] quo_q;
	logic [cbop_pkg::OFF_W-1:0] div_q;

	logic [cbop_pkg::OFF_W:0]   shifted;
	logic [cbop_pkg::OFF_W:0]   diff;
	logic                       ge;

	// One trial subtraction per cycle
	always_comb begin
		shifted = {rem_q, quo_q[cbop_pkg::OFF_W-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
	end

	// Control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[cbop_pkg::OFF_W-1:0] : shifted[cbop_pkg::OFF_W-1:0];
			quo_q <= {quo_q[cbop_pkg::OFF_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/cbop_dp.sv
// Datapath: registers, load counters, overflow marks, owner table, divider, result stage.
module cbop_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cbop_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [cbop_pkg::CFG_W-1:0]    cfg_data,
	input  logic [cbop_pkg::OP_W-1:0]     opcode,
	input  logic                          has_volatile,
	input  logic [cbop_pkg::NODE_W-1:0]   volatile_node,
	input  logic [cbop_pkg::NODE_W-1:0]   snapshot_node,
	input  logic [cbop_pkg::OFF_W-1:0]    record_offset,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [cbop_pkg::NODE_W-1:0]   owner,
	output logic                          design_ready,
	output logic                          out_of_range,
	input  cbop_pkg::cmd_t                cmd,
	output cbop_pkg::status_t             st
);

	localparam logic [cbop_pkg::PART_W-1:0]  MAX_PART_V  =
		cbop_pkg::PART_W'(cbop_pkg::MAX_PARTITIONS);
	localparam logic [cbop_pkg::CHILD_W-1:0] MAX_CHILD_V =
		cbop_pkg::CHILD_W'(cbop_pkg::MAX_CHILDREN);

	// Configuration registers
	logic                          en_q;
	logic [cbop_pkg::PART_W-1:0]   pc_q;
	logic [cbop_pkg::CHILD_W-1:0]  cc_q;
	logic [cbop_pkg::OFF_W-1:0]    bs_q;

	// Latched input beat
	logic [cbop_pkg::OP_W-1:0]     op_q;
	logic [cbop_pkg::NODE_W-1:0]   cand_q;
	logic [cbop_pkg::OFF_W-1:0]    offset_q;

	// Design state
	logic [cbop_pkg::CHILD_W-1:0]  hint_cnt_q;
	logic [cbop_pkg::LOAD_W-1:0]   cap_q;
	logic                          ready_q;
	logic [cbop_pkg::LOAD_W-1:0]   loads_q [cbop_pkg::MAX_PARTITIONS];
	logic [cbop_pkg::MAX_CHILDREN-1:0] marks_q;
	logic [cbop_pkg::NODE_W-1:0]   owner_mem [cbop_pkg::MAX_CHILDREN];
	logic [cbop_pkg::NODE_W-1:0]   mem_rd_q;
	logic                          oor_q;

	// Overflow walk
	logic [cbop_pkg::CHILD_W-1:0]  walk_b_q;
	logic [cbop_pkg::PART_W-1:0]   scan_p_q;
	logic [cbop_pkg::PIDX_W-1:0]   best_q;
	logic [cbop_pkg::LOAD_W-1:0]   best_load_q;

	// Result stage
	logic                          out_valid_q;
	logic [cbop_pkg::NODE_W-1:0]   owner_q;
	logic                          dready_q;
	logic                          oor_out_q;

	// Derived values
	logic [cbop_pkg::PART_W-1:0]   parts;
	logic [cbop_pkg::CHILD_W-1:0]  children;
	logic [cbop_pkg::OFF_W-1:0]    bsize;
	logic [cbop_pkg::PIDX_W-1:0]   lrd_idx;
	logic [cbop_pkg::LOAD_W-1:0]   lrd;
	logic                          ovf;
	logic                          mem_we;
	logic [cbop_pkg::IDX_W-1:0]    mem_wa;
	logic [cbop_pkg::NODE_W-1:0]   mem_wd;
	logic [cbop_pkg::CHILD_W:0]    cnt_next;

	// Divider
	logic                          div_start;
	logic [cbop_pkg::OFF_W-1:0]    div_a;
	logic [cbop_pkg::OFF_W-1:0]    div_d;
	logic                          div_busy;
	logic                          div_done;
	logic [cbop_pkg::OFF_W-1:0]    quo;

	// Clamped register views
	always_comb begin
		if (pc_q == '0)             parts = cbop_pkg::PART_W'(1);
		else if (pc_q > MAX_PART_V) parts = MAX_PART_V;
		else                        parts = pc_q;
		if (cc_q == '0)              children = cbop_pkg::CHILD_W'(1);
		else if (cc_q > MAX_CHILD_V) children = MAX_CHILD_V;
		else                         children = cc_q;
		bsize = (bs_q == '0) ? cbop_pkg::OFF_W'(1) : bs_q;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			pc_q <= cbop_pkg::PART_W'(2);
			cc_q <= cbop_pkg::CHILD_W'(1);
			bs_q <= cbop_pkg::OFF_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbop_pkg::REG_ENABLE:     en_q <= cfg_data[0];
				cbop_pkg::REG_PART_COUNT: pc_q <= cfg_data[cbop_pkg::PART_W-1:0];
				cbop_pkg::REG_CHILD_CNT:  cc_q <= cfg_data[cbop_pkg::CHILD_W-1:0];
				cbop_pkg::REG_BUCKET_SZ:  bs_q <= cfg_data[cbop_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Input beat capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= opcode;
			cand_q   <= has_volatile ? volatile_node : snapshot_node;
			offset_q <= record_offset;
		end
	end

	// Load table read port
	always_comb begin
		case (cmd.lsel)
			cbop_pkg::LSEL_CAND: lrd_idx = cand_q[cbop_pkg::PIDX_W-1:0];
			cbop_pkg::LSEL_SCAN: lrd_idx = scan_p_q[cbop_pkg::PIDX_W-1:0];
			default:             lrd_idx = '0;
		endcase
		lrd = loads_q[lrd_idx];
		ovf = (cbop_pkg::PART_W'(cand_q) >= parts) || (lrd >= cap_q);
		cnt_next = {1'b0, hint_cnt_q} + 1'b1;
	end

	// Hint counter, load cap, ready flag, overflow marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_cnt_q <= '0;
			cap_q      <= '0;
			ready_q    <= 1'b0;
			marks_q    <= '0;
		end else if (cmd.clear) begin
			hint_cnt_q <= '0;
			cap_q      <= '0;
			ready_q    <= 1'b0;
			marks_q    <= '0;
		end else begin
			if (cmd.cap_set) cap_q <= quo[cbop_pkg::LOAD_W-1:0] + 1'b1;
			if (cmd.hint_apply) begin
				hint_cnt_q <= cnt_next[cbop_pkg::CHILD_W-1:0];
				if (ovf) marks_q[hint_cnt_q[cbop_pkg::IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.set_ready) ready_q <= 1'b1;
		end
	end

	// Per-partition loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbop_pkg::MAX_PARTITIONS; i++) loads_q[i] <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < cbop_pkg::MAX_PARTITIONS; i++) loads_q[i] <= '0;
		end else if (cmd.hint_apply && !ovf) begin
			loads_q[cand_q[cbop_pkg::PIDX_W-1:0]] <= lrd + 1'b1;
		end else if (cmd.place) begin
			loads_q[best_q] <= best_load_q + 1'b1;
		end
	end

	// Overflow walk and least-loaded scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_b_q <= '0;
			scan_p_q <= '0;
		end else begin
			if (cmd.walk_init) walk_b_q <= '0;
			else if (cmd.walk_next || cmd.place) walk_b_q <= walk_b_q + 1'b1;
			if (cmd.scan_init) scan_p_q <= cbop_pkg::PART_W'(1);
			else if (cmd.scan_step) scan_p_q <= scan_p_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_q      <= '0;
			best_load_q <= lrd;
		end else if (cmd.scan_step && (lrd < best_load_q)) begin
			best_q      <= scan_p_q[cbop_pkg::PIDX_W-1:0];
			best_load_q <= lrd;
		end
	end

	// Owner table: one write port, one registered read port
	always_comb begin
		mem_we = (cmd.hint_apply && !ovf) || cmd.place;
		mem_wa = cmd.hint_apply ? hint_cnt_q[cbop_pkg::IDX_W-1:0]
		                        : walk_b_q[cbop_pkg::IDX_W-1:0];
		mem_wd = cmd.hint_apply ? cand_q : cbop_pkg::NODE_W'(best_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) owner_mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.cls_look) begin
			mem_rd_q <= owner_mem[quo[cbop_pkg::IDX_W-1:0]];
			oor_q    <= quo >= cbop_pkg::OFF_W'(children);
		end
	end

	// Shared divider: load cap and bucket index
	always_comb begin
		div_start = cmd.cap_start || cmd.cls_start;
		div_a     = cmd.cap_start ? cbop_pkg::OFF_W'(children) : offset_q;
		div_d     = cmd.cap_start ? cbop_pkg::OFF_W'(parts) : bsize;
	end

	cbop_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_d),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// Result stage: holds a beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (!en_q) begin
				owner_q   <= '0;
				dready_q  <= 1'b1;
				oor_out_q <= 1'b0;
			end else begin
				owner_q   <= (ready_q && !oor_q) ? mem_rd_q : '0;
				dready_q  <= ready_q;
				oor_out_q <= oor_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign owner        = owner_q;
	assign design_ready = dready_q;
	assign out_of_range = oor_out_q;

	// Status to controller
	always_comb begin
		st.op        = op_q;
		st.hint_skip = ready_q || (hint_cnt_q >= children);
		st.cnt_zero  = (hint_cnt_q == '0);
		st.hint_last = cnt_next >= {1'b0, children};
		st.enabled   = en_q;
		st.div_done  = div_done;
		st.div_busy  = div_busy;
		st.walk_end  = walk_b_q >= children;
		st.mark_hit  = marks_q[walk_b_q[cbop_pkg::IDX_W-1:0]];
		st.scan_end  = scan_p_q >= parts;
		st.out_free  = !out_valid_q || out_ready;
	end

endmodule

### rtl/cbop_ctrl.sv
// Controller state machine: decodes beats and sequences hints, rebalance and classify.
module cbop_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cbop_pkg::status_t st,
	output cbop_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CAP    = 4'd2;
	localparam logic [3:0] S_HINT   = 4'd3;
	localparam logic [3:0] S_WALK   = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_PLACE  = 4'd6;
	localparam logic [3:0] S_CLSDIV = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.lsel = cbop_pkg::LSEL_CAND;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.op)
					cbop_pkg::OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
					cbop_pkg::OP_HINT: begin
						if (st.hint_skip) begin
							state_d = S_IDLE;
						end else if (st.cnt_zero) begin
							cmd.cap_start = 1'b1;
							state_d       = S_CAP;
						end else begin
							state_d = S_HINT;
						end
					end
					cbop_pkg::OP_CLASSIFY: begin
						if (!st.enabled) begin
							state_d = S_DONE;
						end else begin
							cmd.cls_start = 1'b1;
							state_d       = S_CLSDIV;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_CAP: begin
				if (st.div_done) begin
					cmd.cap_set = 1'b1;
					state_d     = S_HINT;
				end
			end
			S_HINT: begin
				cmd.hint_apply = 1'b1;
				if (st.hint_last) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.lsel = cbop_pkg::LSEL_ZERO;
				if (st.walk_end) begin
					cmd.set_ready = 1'b1;
					state_d       = S_IDLE;
				end else if (st.mark_hit) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.lsel = cbop_pkg::LSEL_SCAN;
				if (st.scan_end) state_d = S_PLACE;
				else cmd.scan_step = 1'b1;
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_WALK;
			end
			S_CLSDIV: begin
				if (st.div_done) begin
					cmd.cls_look = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

### rtl/capped_bucket_owner_partitioner.sv
// Top level of the capped bucket owner partitioner.
//
// Input channel (in_valid/in_ready) takes one beat at a time: clear, bucket
// hint or classify. Only classify returns a beat on the output channel
// (out_valid/out_ready) carrying owner, design_ready and out_of_range.
// The first hint after a clear computes the load cap on the shared
// bit-serial divider. The last hint runs the rebalance walk over the buckets,
// with a least-loaded scan over the load counters, one partition per cycle,
// for each overflow bucket. A classify computes its bucket index on the
// 48-step divider; with partitioning disabled it skips the divider.
// The result sits in an output register; a stalled receiver holds it there
// while the next beat is accepted, and the controller waits only when a new
// result finds that register still full.
// Reset clears configuration to defaults, the hint count, loads, overflow
// marks and ready flag; the owner table is not cleared. cfg_we writes a
// register, but the user must assert it only while the block is idle;
// the block itself does not enforce this.
module capped_bucket_owner_partitioner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cbop_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [cbop_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cbop_pkg::OP_W-1:0]     opcode,
	input  logic                          has_volatile,
	input  logic [cbop_pkg::NODE_W-1:0]   volatile_node,
	input  logic [cbop_pkg::NODE_W-1:0]   snapshot_node,
	input  logic [cbop_pkg::OFF_W-1:0]    record_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cbop_pkg::NODE_W-1:0]   owner,
	output logic                          design_ready,
	output logic                          out_of_range
);

	cbop_pkg::cmd_t    cmd;
	cbop_pkg::status_t st;

	cbop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cbop_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.has_volatile  (has_volatile),
		.volatile_node (volatile_node),
		.snapshot_node (snapshot_node),
		.record_offset (record_offset),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.owner         (owner),
		.design_ready  (design_ready),
		.out_of_range  (out_of_range),
		.cmd           (cmd),
		.st            (st)
	);

	// A classify beat keeps the block busy on the next cycle
	a_cls_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == cbop_pkg::OP_CLASSIFY) |=> !in_ready)
		else $error("classify beat did not occupy the controller");

	// Divider is never running while the block takes beats
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !st.div_busy)
		else $error("divider busy while idle");

	// Out-of-range bucket reports owner zero
	a_oor_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (owner == '0))
		else $error("out-of-range result with nonzero owner");

	// Not-ready design reports owner zero
	a_nrdy_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !design_ready) |-> (owner == '0))
		else $error("not-ready result with nonzero owner");

endmodule
